/* rtl/ctw_pkg.sv */
`default_nettype none

package ctw_pkg;

  // Window geometry
  localparam int unsigned WINDOW_HALF = 2;
  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned WSIDE       = 2 * WINDOW_HALF + 1;
  localparam int unsigned LROWS       = 2 * WINDOW_HALF;
  localparam int unsigned CENTER_IDX  = WINDOW_HALF * WSIDE + WINDOW_HALF;
  localparam int unsigned CENSUS_BITS = WSIDE * WSIDE - 1;
  localparam int unsigned CENSUS_EXT  = (CENSUS_BITS > 24) ? CENSUS_BITS : 24;

  // Field and counter widths
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned WIDTH_W  = 11;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned OCOL_W   = 10;
  localparam int unsigned CENSUS_W = 24;
  localparam int unsigned COL_W    = $clog2(MAX_WIDTH);
  localparam int unsigned SLOT_W   = $clog2(LROWS);
  localparam int unsigned EXT_W    = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
  localparam int unsigned CFG_W    = 16;

  // Register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0]            pixel_t;
  typedef logic [WSIDE-1:0][PIX_W-1:0] column_t;

  // Line buffer access for one beat: read all banks at addr, write one bank
  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  addr;
    logic [SLOT_W-1:0] slot;
    pixel_t            pixel;
  } lb_req_t;

  // Item held between the line buffer read and the window shift
  typedef struct packed {
    logic              prod;
    logic              done;
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic [SLOT_W-1:0] slot;
    pixel_t            pixel;
  } item_t;

endpackage

`default_nettype wire

/* rtl/ctw_line_buffer.sv */
`default_nettype none

module ctw_line_buffer (
  input  wire logic                                   clk_i,
  input  wire ctw_pkg::lb_req_t                       req_i,
  output logic [ctw_pkg::LROWS-1:0][ctw_pkg::PIX_W-1:0] rdata_o
);

  // One bank per buffered row slot, read-before-write at the same address
  for (genvar k = 0; k < ctw_pkg::LROWS; k++) begin : g_bank
    ctw_pkg::pixel_t mem [ctw_pkg::MAX_WIDTH];
    ctw_pkg::pixel_t rd_q;

    always_ff @(posedge clk_i) begin
      if (req_i.en) begin
        rd_q <= mem[req_i.addr];
        if (req_i.slot == ctw_pkg::SLOT_W'(k)) begin
          mem[req_i.addr] <= req_i.pixel;
        end
      end
    end

    assign rdata_o[k] = rd_q;
  end

endmodule

`default_nettype wire

/* rtl/ctw_column_cell.sv */
`default_nettype none

module ctw_column_cell (
  input  wire logic             clk_i,
  input  wire logic             shift_i,
  input  wire ctw_pkg::column_t col_i,
  input  wire ctw_pkg::pixel_t  center_i,
  output ctw_pkg::column_t      col_o,
  output logic [ctw_pkg::WSIDE-1:0] lt_o
);

  ctw_pkg::column_t col_q;

  // Window column; takes its right neighbor's column on every shift
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  // Census bits of the incoming column against the incoming center
  always_comb begin
    for (int i = 0; i < ctw_pkg::WSIDE; i++) begin
      lt_o[i] = (col_i[i] < center_i);
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

/* rtl/census_transform_window.sv */
// An accepted pixel beat is held in stage 1, then in the output register, before its census word beat.
// Throughput: one pixel per cycle while out_ready_i does not stall a result beat, set by the
// line buffer banks, each doing one read and one write per cycle, and by the window shifting one column per beat.
// Reset: row/column counters and beat valids clear, width returns to 640 and
// height to 480. Line buffer contents are not cleared; no clearing pass.
`default_nettype none

module census_transform_window (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Pixel input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ctw_pkg::PIX_W-1:0]     pixel_i,
  input  wire logic                          frame_start_i,
  // Census output channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ctw_pkg::CENSUS_W-1:0]       census_word_o,
  output logic [ctw_pkg::ROW_W-1:0]          out_row_o,
  output logic [ctw_pkg::OCOL_W-1:0]         out_col_o,
  output logic                               frame_done_o,
  // Configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [ctw_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned EW = ctw_pkg::EXT_W;

  // Configuration registers
  logic [ctw_pkg::WIDTH_W-1:0]  width_q;
  logic [ctw_pkg::HEIGHT_W-1:0] height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ctw_pkg::WIDTH_W'(640);
      height_q <= ctw_pkg::HEIGHT_W'(480);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ctw_pkg::REG_WIDTH:  width_q  <= cfg_data_i[ctw_pkg::WIDTH_W-1:0];
        ctw_pkg::REG_HEIGHT: height_q <= cfg_data_i[ctw_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective bounds
  logic [EW-1:0]                w_ext, w_eff;
  logic [ctw_pkg::HEIGHT_W-1:0] h_eff;

  always_comb begin
    w_ext = EW'(width_q);
    if (w_ext == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > EW'(ctw_pkg::MAX_WIDTH)) begin
      w_eff = EW'(ctw_pkg::MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (height_q == '0) ? ctw_pkg::HEIGHT_W'(1) : height_q;
  end

  // Handshake across the pipeline
  ctw_pkg::item_t s1_q, s1_d;
  logic           s1_v_q;
  logic           out_v_q;
  logic           out_free, s1_go, in_acc;

  assign out_free   = !out_v_q || out_ready_i;
  assign s1_go      = s1_v_q && (!s1_q.prod || out_free);
  assign in_ready_o = !s1_v_q || s1_go;
  assign in_acc     = in_valid_i && in_ready_o;

  // Position counters
  logic [ctw_pkg::COL_W-1:0]  col_q, col_d, c_cur;
  logic [ctw_pkg::ROW_W-1:0]  row_q, row_d, r_cur;
  logic [ctw_pkg::SLOT_W-1:0] slot_q, slot_d, slot_cur;
  logic [EW-1:0]              c_ext, c_inc;
  logic [ctw_pkg::ROW_W:0]    r_inc;

  always_comb begin
    c_cur    = frame_start_i ? '0 : col_q;
    r_cur    = frame_start_i ? '0 : row_q;
    slot_cur = frame_start_i ? '0 : slot_q;
    c_ext    = EW'(c_cur);
    c_inc    = c_ext + EW'(1);
    r_inc    = {1'b0, r_cur} + (ctw_pkg::ROW_W + 1)'(1);
    col_d    = c_inc[ctw_pkg::COL_W-1:0];
    row_d    = r_cur;
    slot_d   = slot_cur;
    if (c_inc >= w_eff) begin
      col_d = '0;
      if (r_inc >= {1'b0, h_eff}) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = r_inc[ctw_pkg::ROW_W-1:0];
        slot_d = (slot_cur == ctw_pkg::SLOT_W'(ctw_pkg::LROWS - 1)) ? '0
               : slot_cur + ctw_pkg::SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (in_acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  // Result decision for the accepted pixel
  always_comb begin
    s1_d.prod  = (r_cur >= ctw_pkg::ROW_W'(ctw_pkg::LROWS))
              && (c_ext >= EW'(ctw_pkg::LROWS))
              && (r_cur < h_eff) && (c_ext < w_eff);
    s1_d.done  = (r_cur == h_eff - ctw_pkg::HEIGHT_W'(1)) && (c_ext == w_eff - EW'(1));
    s1_d.row   = r_cur - ctw_pkg::ROW_W'(ctw_pkg::LROWS);
    s1_d.col   = ctw_pkg::OCOL_W'(c_cur - ctw_pkg::COL_W'(ctw_pkg::LROWS));
    s1_d.slot  = slot_cur;
    s1_d.pixel = pixel_i;
  end

  // Line buffer: read the buffered column, store the new pixel
  ctw_pkg::lb_req_t                               lb_req;
  logic [ctw_pkg::LROWS-1:0][ctw_pkg::PIX_W-1:0] lb_rdata;

  assign lb_req.en    = in_acc;
  assign lb_req.addr  = c_cur;
  assign lb_req.slot  = slot_cur;
  assign lb_req.pixel = pixel_i;

  ctw_line_buffer u_line_buffer (
    .clk_i   (clk_i),
    .req_i   (lb_req),
    .rdata_o (lb_rdata)
  );

  // Stage 1 holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q <= 1'b1;
    end else if (s1_go) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // New window column, oldest row on top
  ctw_pkg::column_t       new_col;
  logic [ctw_pkg::SLOT_W:0] bank_sel;

  always_comb begin
    new_col = '0;
    for (int k = 0; k < ctw_pkg::LROWS; k++) begin
      bank_sel = {1'b0, s1_q.slot} + (ctw_pkg::SLOT_W + 1)'(k);
      if (bank_sel >= (ctw_pkg::SLOT_W + 1)'(ctw_pkg::LROWS)) begin
        bank_sel = bank_sel - (ctw_pkg::SLOT_W + 1)'(ctw_pkg::LROWS);
      end
      new_col[k] = lb_rdata[bank_sel[ctw_pkg::SLOT_W-1:0]];
    end
    new_col[ctw_pkg::LROWS] = s1_q.pixel;
  end

  // Chain of window column cells, leftmost is oldest
  ctw_pkg::column_t                        cell_in  [ctw_pkg::WSIDE];
  ctw_pkg::column_t                        cell_out [ctw_pkg::WSIDE];
  logic [ctw_pkg::WSIDE-1:0]               cell_lt  [ctw_pkg::WSIDE];
  ctw_pkg::pixel_t                         center;

  assign center = cell_in[ctw_pkg::WINDOW_HALF][ctw_pkg::WINDOW_HALF];

  for (genvar j = 0; j < ctw_pkg::WSIDE; j++) begin : g_cell
    if (j == ctw_pkg::WSIDE - 1) begin : g_head
      assign cell_in[j] = new_col;
    end else begin : g_link
      assign cell_in[j] = cell_out[j+1];
    end

    ctw_column_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (s1_go),
      .col_i    (cell_in[j]),
      .center_i (center),
      .col_o    (cell_out[j]),
      .lt_o     (cell_lt[j])
    );
  end

  // Census word, row-major scan with the center skipped, top-left in the MSB
  logic [ctw_pkg::CENSUS_BITS-1:0] census_full;
  logic [ctw_pkg::CENSUS_EXT-1:0]  census_ext;

  always_comb begin
    census_full = '0;
    for (int i = 0; i < ctw_pkg::WSIDE; i++) begin
      for (int j = 0; j < ctw_pkg::WSIDE; j++) begin
        if (i * ctw_pkg::WSIDE + j < ctw_pkg::CENTER_IDX) begin
          census_full[ctw_pkg::CENSUS_BITS - 1 - (i * ctw_pkg::WSIDE + j)] = cell_lt[j][i];
        end else if (i * ctw_pkg::WSIDE + j > ctw_pkg::CENTER_IDX) begin
          census_full[ctw_pkg::CENSUS_BITS - (i * ctw_pkg::WSIDE + j)] = cell_lt[j][i];
        end
      end
    end
    census_ext = ctw_pkg::CENSUS_EXT'(census_full);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_go && s1_q.prod) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  logic [ctw_pkg::CENSUS_W-1:0] census_q;
  logic [ctw_pkg::ROW_W-1:0]    orow_q;
  logic [ctw_pkg::OCOL_W-1:0]   ocol_q;
  logic                         odone_q;

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_q.prod) begin
      census_q <= census_ext[ctw_pkg::CENSUS_W-1:0];
      orow_q   <= s1_q.row;
      ocol_q   <= s1_q.col;
      odone_q  <= s1_q.done;
    end
  end

  assign out_valid_o   = out_v_q;
  assign census_word_o = census_q;
  assign out_row_o     = orow_q;
  assign out_col_o     = ocol_q;
  assign frame_done_o  = odone_q;

  // Checks
  a_accept_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s1_v_q) |-> s1_go)
    else $error("pixel beat accepted over an item still held in stage 1");

  a_stage1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_go) |=> (s1_v_q && $stable(s1_q)))
    else $error("stalled stage 1 item changed");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_q.prod) |=> out_v_q)
    else $error("producing item left stage 1 without a result beat");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s1_go && s1_q.prod))
    else $error("result beat appeared without a producing item");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= ctw_pkg::SLOT_W'(ctw_pkg::LROWS - 1))
    else $error("row slot out of range");

endmodule

`default_nettype wire
